// ===== hw/rtl/crv_pkg.sv =====
// Shared types, CORDIC constant tables and helper functions for the rotate/vector unit.
package crv_pkg;

  typedef enum logic {
    FUNC_ROTATE = 1'b0,
    FUNC_VECTOR = 1'b1
  } func_e;

  // Final angle correction applied in vectoring mode, chosen from the input signs.
  typedef enum logic [1:0] {
    QD_DIRECT,
    QD_HALF_MINUS,
    QD_HALF_PLUS,
    QD_FULL_MINUS
  } quad_e;

  typedef struct packed {
    logic               func;
    logic signed [15:0] angle;
    logic signed [15:0] x_value;
    logic signed [15:0] y_value;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] result_x;
    logic signed [15:0] result_y;
  } out_word_t;

  // Control that travels alongside the datapath through every stage.
  typedef struct packed {
    func_e func;
    logic  cos_neg;
    logic  sin_neg;
    quad_e quad;
  } side_t;

  localparam int unsigned ATAN_LEN = 24;

  // atan(2^-j) in Q30.
  localparam logic [63:0] ATAN_Q30 [ATAN_LEN] = '{
    64'd843314857, 64'd497837829, 64'd263043837, 64'd133525159,
    64'd67021687,  64'd33543516,  64'd16775851,  64'd8388437,
    64'd4194283,   64'd2097149,   64'd1048576,   64'd524288,
    64'd262144,    64'd131072,    64'd65536,     64'd32768,
    64'd16384,     64'd8192,      64'd4096,      64'd2048,
    64'd1024,      64'd512,       64'd256,       64'd128
  };

  // pi/2, pi, 3pi/2 and 2pi in Q30.
  localparam logic [63:0] QUAR_Q30 = 64'd1686629713;
  localparam logic [63:0] HALF_Q30 = 64'd3373259426;
  localparam logic [63:0] THQU_Q30 = 64'd5059889139;
  localparam logic [63:0] FULL_Q30 = 64'd6746518852;

  // The gain compensation is a 13-term shift-add; a set bit k subtracts d >>> k.
  localparam int unsigned SCALE_TERMS = 13;
  localparam logic [SCALE_TERMS-1:0] SCALE_SUB = 13'h049A;

  // Round a Q30 constant half-up to the given number of fraction bits.
  function automatic logic [63:0] from_q30(logic [63:0] q, int unsigned frac);
    return (q + (64'd1 << (29 - frac))) >> (30 - frac);
  endfunction

endpackage

// ===== hw/rtl/crv_rot_stage.sv =====
// One registered CORDIC micro-rotation stage with a fixed shift and table angle.
module crv_rot_stage #(
  parameter int unsigned           WIDTH = 16,
  parameter int unsigned           SHIFT = 0,
  parameter logic [WIDTH-1:0]      PHASE = '0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  crv_pkg::side_t           side_i,
  input  logic signed [WIDTH-1:0]  x_i,
  input  logic signed [WIDTH-1:0]  y_i,
  input  logic signed [WIDTH-1:0]  z_i,
  output logic                     valid_o,
  output crv_pkg::side_t           side_o,
  output logic signed [WIDTH-1:0]  x_o,
  output logic signed [WIDTH-1:0]  y_o,
  output logic signed [WIDTH-1:0]  z_o
);

  logic                    valid_q;
  crv_pkg::side_t          side_q;
  logic signed [WIDTH-1:0] x_q, y_q, z_q;
  logic signed [WIDTH-1:0] x_d, y_d, z_d;
  logic signed [WIDTH-1:0] xs, ys;
  logic                    pos_dir;

  assign xs = x_i >>> SHIFT;
  assign ys = y_i >>> SHIFT;

  // Vectoring drives y toward zero, rotation drives the residual angle toward zero.
  assign pos_dir = (side_i.func == crv_pkg::FUNC_VECTOR) ? y_i[WIDTH-1] : ~z_i[WIDTH-1];

  always_comb begin
    if (pos_dir) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - PHASE;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + PHASE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q <= side_i;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;

endmodule

// ===== hw/rtl/cordic_rotate_vector.sv =====
// Pipelined CORDIC unit for rotation (sin/cos) and vectoring (magnitude/angle).
//
//   channel   handshake          payload              direction
//   job       start / busy       job_i  (in_word_t)   in
//   result    done_o strobe      result_o (out_word_t) out
//
// A word is taken on every cycle that start is high; busy never rises.
// Each word passes through one fold stage, one stage per micro-rotation,
// thirteen gain compensation stages and the output stage.
// Throughput is one word per cycle.
// Reset clears the valid bits only; the receiver cannot stall, so nothing is held.
module cordic_rotate_vector #(
  parameter int unsigned WIDTH      = 16,
  parameter int unsigned FRAC_BITS  = 12,
  parameter int unsigned ITERATIONS = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  crv_pkg::in_word_t  job_i,
  output logic               done_o,
  output crv_pkg::out_word_t result_o
);

  localparam int unsigned NSC = crv_pkg::SCALE_TERMS;

  localparam logic [63:0] QUAR_L = crv_pkg::from_q30(crv_pkg::QUAR_Q30, FRAC_BITS);
  localparam logic [63:0] HALF_L = crv_pkg::from_q30(crv_pkg::HALF_Q30, FRAC_BITS);
  localparam logic [63:0] THQU_L = crv_pkg::from_q30(crv_pkg::THQU_Q30, FRAC_BITS);
  localparam logic [63:0] FULL_L = crv_pkg::from_q30(crv_pkg::FULL_Q30, FRAC_BITS);
  localparam logic signed [WIDTH-1:0] QUAR = QUAR_L[WIDTH-1:0];
  localparam logic signed [WIDTH-1:0] HALF = HALF_L[WIDTH-1:0];
  localparam logic signed [WIDTH-1:0] THQU = THQU_L[WIDTH-1:0];
  localparam logic signed [WIDTH-1:0] FULL = FULL_L[WIDTH-1:0];

  assign busy = 1'b0;

  // ---------------- Input fold stage ----------------
  logic signed [31:0]      ang32, x32, y32;
  logic signed [WIDTH-1:0] ang_w, x_w, y_w;
  logic signed [WIDTH-1:0] rot_th, x_abs, y_abs;
  logic                    cos_neg, sin_neg;
  crv_pkg::quad_e          quad;

  logic                    s0_valid_q;
  crv_pkg::side_t          s0_side_q, s0_side_d;
  logic signed [WIDTH-1:0] s0_x_q, s0_y_q, s0_z_q;
  logic signed [WIDTH-1:0] s0_x_d, s0_y_d, s0_z_d;

  assign ang32 = 32'(job_i.angle);
  assign x32   = 32'(job_i.x_value);
  assign y32   = 32'(job_i.y_value);
  assign ang_w = ang32[WIDTH-1:0];
  assign x_w   = x32[WIDTH-1:0];
  assign y_w   = y32[WIDTH-1:0];

  // Quadrant fold for rotation; the cosine and sine signs are restored at the end.
  always_comb begin
    rot_th  = ang_w;
    cos_neg = 1'b0;
    sin_neg = 1'b0;
    if (ang_w >= QUAR && ang_w < HALF) begin
      rot_th  = HALF - ang_w;
      cos_neg = 1'b1;
    end else if (ang_w >= HALF && ang_w < THQU) begin
      rot_th  = ang_w - HALF;
      cos_neg = 1'b1;
      sin_neg = 1'b1;
    end else if (ang_w >= THQU && ang_w <= FULL) begin
      rot_th  = FULL - ang_w;
      sin_neg = 1'b1;
    end
  end

  assign x_abs = x_w[WIDTH-1] ? -x_w : x_w;
  assign y_abs = y_w[WIDTH-1] ? -y_w : y_w;

  always_comb begin
    if (x_w[WIDTH-1] && !y_w[WIDTH-1]) begin
      quad = crv_pkg::QD_HALF_MINUS;
    end else if ((x_w[WIDTH-1] || x_w == '0) && y_w[WIDTH-1]) begin
      quad = crv_pkg::QD_HALF_PLUS;
    end else if (!x_w[WIDTH-1] && x_w != '0 && y_w[WIDTH-1]) begin
      quad = crv_pkg::QD_FULL_MINUS;
    end else begin
      quad = crv_pkg::QD_DIRECT;
    end
  end

  always_comb begin
    if (job_i.func == crv_pkg::FUNC_VECTOR) begin
      s0_side_d.func    = crv_pkg::FUNC_VECTOR;
      s0_side_d.cos_neg = 1'b0;
      s0_side_d.sin_neg = 1'b0;
      s0_side_d.quad    = quad;
      s0_x_d            = x_abs;
      s0_y_d            = y_abs;
      s0_z_d            = '0;
    end else begin
      s0_side_d.func    = crv_pkg::FUNC_ROTATE;
      s0_side_d.cos_neg = cos_neg;
      s0_side_d.sin_neg = sin_neg;
      s0_side_d.quad    = crv_pkg::QD_DIRECT;
      s0_x_d            = x_w;
      s0_y_d            = y_w;
      s0_z_d            = rot_th;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_side_q <= s0_side_d;
    s0_x_q    <= s0_x_d;
    s0_y_q    <= s0_y_d;
    s0_z_q    <= s0_z_d;
  end

  // ---------------- Micro-rotation stages ----------------
  logic                    rv_valid [0:ITERATIONS];
  crv_pkg::side_t          rv_side  [0:ITERATIONS];
  logic signed [WIDTH-1:0] rv_x     [0:ITERATIONS];
  logic signed [WIDTH-1:0] rv_y     [0:ITERATIONS];
  logic signed [WIDTH-1:0] rv_z     [0:ITERATIONS];

  assign rv_valid[0] = s0_valid_q;
  assign rv_side[0]  = s0_side_q;
  assign rv_x[0]     = s0_x_q;
  assign rv_y[0]     = s0_y_q;
  assign rv_z[0]     = s0_z_q;

  for (genvar j = 0; j < ITERATIONS; j++) begin : g_rot
    localparam logic [63:0] PH64 = crv_pkg::from_q30(crv_pkg::ATAN_Q30[j], FRAC_BITS);

    crv_rot_stage #(
      .WIDTH (WIDTH),
      .SHIFT (j),
      .PHASE (PH64[WIDTH-1:0])
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (rv_valid[j]),
      .side_i  (rv_side[j]),
      .x_i     (rv_x[j]),
      .y_i     (rv_y[j]),
      .z_i     (rv_z[j]),
      .valid_o (rv_valid[j+1]),
      .side_o  (rv_side[j+1]),
      .x_o     (rv_x[j+1]),
      .y_o     (rv_y[j+1]),
      .z_o     (rv_z[j+1])
    );
  end

  // ---------------- Gain compensation stages ----------------
  logic                    sc_valid [0:NSC];
  crv_pkg::side_t          sc_side  [0:NSC];
  logic signed [WIDTH-1:0] sc_dx    [0:NSC];
  logic signed [WIDTH-1:0] sc_dy    [0:NSC];
  logic signed [WIDTH-1:0] sc_ax    [0:NSC];
  logic signed [WIDTH-1:0] sc_ay    [0:NSC];
  logic signed [WIDTH-1:0] sc_th    [0:NSC];

  assign sc_valid[0] = rv_valid[ITERATIONS];
  assign sc_side[0]  = rv_side[ITERATIONS];
  assign sc_dx[0]    = rv_x[ITERATIONS];
  assign sc_dy[0]    = rv_y[ITERATIONS];
  assign sc_ax[0]    = '0;
  assign sc_ay[0]    = '0;
  assign sc_th[0]    = rv_z[ITERATIONS];

  for (genvar k = 0; k < NSC; k++) begin : g_scale
    localparam logic SUB = crv_pkg::SCALE_SUB[k];

    logic                    vld_q;
    crv_pkg::side_t          side_q;
    logic signed [WIDTH-1:0] dx_q, dy_q, ax_q, ay_q, th_q;
    logic signed [WIDTH-1:0] ax_d, ay_d, tx, ty;

    assign tx   = sc_dx[k] >>> k;
    assign ty   = sc_dy[k] >>> k;
    assign ax_d = SUB ? sc_ax[k] - tx : sc_ax[k] + tx;
    assign ay_d = SUB ? sc_ay[k] - ty : sc_ay[k] + ty;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= sc_valid[k];
      end
    end

    always_ff @(posedge clk_i) begin
      side_q <= sc_side[k];
      dx_q   <= sc_dx[k];
      dy_q   <= sc_dy[k];
      ax_q   <= ax_d;
      ay_q   <= ay_d;
      th_q   <= sc_th[k];
    end

    assign sc_valid[k+1] = vld_q;
    assign sc_side[k+1]  = side_q;
    assign sc_dx[k+1]    = dx_q;
    assign sc_dy[k+1]    = dy_q;
    assign sc_ax[k+1]    = ax_q;
    assign sc_ay[k+1]    = ay_q;
    assign sc_th[k+1]    = th_q;
  end

  // ---------------- Sign restore and output register ----------------
  crv_pkg::side_t          fin_side;
  logic signed [WIDTH-1:0] fin_ax, fin_ay, fin_th;
  logic signed [WIDTH-1:0] rx_w, ry_w, vec_ang;
  logic signed [31:0]      rx32, ry32;
  logic                    done_q;
  crv_pkg::out_word_t      result_q, result_d;

  assign fin_side = sc_side[NSC];
  assign fin_ax   = sc_ax[NSC];
  assign fin_ay   = sc_ay[NSC];
  assign fin_th   = sc_th[NSC];

  always_comb begin
    case (fin_side.quad)
      crv_pkg::QD_HALF_MINUS: vec_ang = HALF - fin_th;
      crv_pkg::QD_HALF_PLUS:  vec_ang = HALF + fin_th;
      crv_pkg::QD_FULL_MINUS: vec_ang = FULL - fin_th;
      default:                vec_ang = fin_th;
    endcase
  end

  assign rx_w = fin_side.cos_neg ? -fin_ax : fin_ax;

  always_comb begin
    if (fin_side.func == crv_pkg::FUNC_VECTOR) begin
      ry_w = vec_ang;
    end else if (fin_side.sin_neg) begin
      ry_w = -fin_ay;
    end else begin
      ry_w = fin_ay;
    end
  end

  assign rx32              = 32'(rx_w);
  assign ry32              = 32'(ry_w);
  assign result_d.result_x = rx32[15:0];
  assign result_d.result_y = ry32[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= sc_valid[NSC];
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule
